// ===== rtl/ldf_pkg.sv =====
// Shared types, constants and helper functions for the LIDAR packet deframer.
// No dependencies; used by all rtl/ldf_* modules and the top level.
`timescale 1ns / 1ps

package ldf_pkg;

    localparam int PACKET_BYTES        = 22;
    localparam int READINGS_PER_PACKET = 4;

    localparam int POS_W    = 5;   // byte position inside a packet
    localparam int READ_W   = 2;   // reading number
    localparam int ANGLE_W  = 9;
    localparam int DIST_W   = 15;
    localparam int ACC_W    = 26;  // ten folds of a 16-bit word
    localparam int SUM_W    = 15;
    localparam int BASE_W   = 11;  // index*4 + offset, before mod 360
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [7:0]         START_BYTE    = 8'hFA;
    localparam logic [POS_W-1:0]   POS_INDEX     = 5'd1;
    localparam logic [POS_W-1:0]   POS_FIRST_RD  = 5'd4;
    localparam logic [POS_W-1:0]   POS_CSUM_LO   = 5'd20;
    localparam logic [POS_W-1:0]   POS_CSUM_HI   = 5'd21;
    localparam logic [READ_W-1:0]  LAST_READING  = 2'd3;
    localparam logic [DIST_W-1:0]  DIST_INVALID  = 15'h7FFF;
    localparam logic [ANGLE_W-1:0] ANGLE_OFFSET_RESET = 9'd257;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 1'd1;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_offset;
        logic               check_enable;
    } cfg_t;

    // one finished packet, handed from collector to emitter
    typedef struct packed {
        logic                                 done;
        logic                                 bad;
        logic [ANGLE_W-1:0]                   base_angle;
        logic [READINGS_PER_PACKET-1:0][DIST_W-1:0] distance;
    } pkt_t;

    // x < 1532 reduced mod 360 by three conditional subtracts
    function automatic logic [ANGLE_W-1:0] mod360(input logic [BASE_W-1:0] x);
        logic [BASE_W-1:0] t;
        t = x;
        if (t >= BASE_W'(1440)) t = t - BASE_W'(1440);
        if (t >= BASE_W'(720))  t = t - BASE_W'(720);
        if (t >= BASE_W'(360))  t = t - BASE_W'(360);
        return t[ANGLE_W-1:0];
    endfunction

endpackage

// ===== rtl/lidar_packet_deframer_top.sv =====
// Top level of the LIDAR packet deframer: config registers, collector, emitter.
// Depends on ldf_pkg, ldf_cfg_regs, ldf_collector, ldf_emitter.
`timescale 1ns / 1ps

// Channel   Dir  Word contents (low bit first)                Handshake
// s_        in   tdata[7:0] rx_byte                            s_tvalid/s_tready
// m_        out  tdata[8:0] angle, [23:9] distance (unsigned); m_tvalid/m_tready
//                tuser checksum_bad; tlast last_reading
// cfg_      in   cfg_index (0 angle_offset, 1 check_enable),   cfg_valid/cfg_ready
//                cfg_data
//
// One byte is taken per cycle while s_tready is high. Bytes are hunted for
// 0xFA, which opens a 22-byte packet collected with a running checksum; the
// last byte loads four readings into the output buffer, which sends one per
// cycle while m_tready is high. s_tready drops only on a packet's final byte
// while the previous packet's readings are still unsent; cfg_ready is always high.
// aresetn is synchronous, active low: hunting, output buffer empty,
// angle_offset 257, check_enable 0.

module lidar_packet_deframer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // byte input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    // reading output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [8:0] angle, [23:9] distance
    output logic                           m_tuser,   // [0] checksum_bad
    output logic                           m_tlast,   // last_reading
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ldf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldf_pkg::CFG_DATA_W-1:0] cfg_data
);

    ldf_pkg::cfg_t cfg;
    ldf_pkg::pkt_t pkt;
    logic          out_busy;

    ldf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // byte capture and checksum; decodes a packet on its final byte
    ldf_collector u_collector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .rx_byte    (s_tdata),
        .out_busy   (out_busy),
        .cfg        (cfg),
        .pkt        (pkt)
    );

    // four-reading output buffer
    ldf_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pkt      (pkt),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/ldf_cfg_regs.sv =====
// Configuration registers of the LIDAR packet deframer.
// Depends on ldf_pkg.
`timescale 1ns / 1ps

module ldf_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ldf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldf_pkg::CFG_DATA_W-1:0] cfg_data,
    output ldf_pkg::cfg_t                 cfg
);

    logic [ldf_pkg::ANGLE_W-1:0] offset_reg, offset_next;
    logic                        check_en_reg, check_en_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        offset_next   = offset_reg;
        check_en_next = check_en_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ldf_pkg::CFG_ANGLE_OFFSET: offset_next   = cfg_data;
                ldf_pkg::CFG_CHECK_ENABLE: check_en_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= ldf_pkg::ANGLE_OFFSET_RESET;
            check_en_reg <= 1'b0;
        end else begin
            offset_reg   <= offset_next;
            check_en_reg <= check_en_next;
        end
    end

    assign cfg.angle_offset = offset_reg;
    assign cfg.check_enable = check_en_reg;

endmodule

// ===== rtl/ldf_collector.sv =====
// Start-byte hunt, packet field capture and running checksum.
// Depends on ldf_pkg; feeds ldf_emitter.
`timescale 1ns / 1ps

module ldf_collector (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  logic [7:0]    rx_byte,
    input  logic          out_busy,
    input  ldf_pkg::cfg_t cfg,
    output ldf_pkg::pkt_t pkt
);

    localparam int NR = ldf_pkg::READINGS_PER_PACKET;

    logic                          in_packet_reg, in_packet_next;
    logic [ldf_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [ldf_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [7:0]                    lo_hold_reg, lo_hold_next;  // low byte of current word
    logic [7:0]                    index_reg, index_next;
    logic [7:0]                    csum_lo_reg, csum_lo_next;
    logic [NR-1:0][7:0]            dlo_reg, dlo_next;
    logic [NR-1:0][5:0]            dhi_reg, dhi_next;
    logic [NR-1:0]                 inval_reg, inval_next;

    logic                          accept;
    logic                          last_byte;
    logic [ldf_pkg::READ_W-1:0]    rd_sel;
    logic [ldf_pkg::POS_W-1:0]     rd_pos;
    logic [15:0]                   fold;
    logic [ldf_pkg::SUM_W-1:0]     sum;
    logic                          bad;
    logic [ldf_pkg::BASE_W-1:0]    base;

    assign last_byte  = in_packet_reg && (pos_reg == ldf_pkg::POS_CSUM_HI);
    // final byte waits while the previous packet's readings are still queued
    assign byte_ready = !(last_byte && out_busy);
    assign accept     = byte_valid && byte_ready;

    assign rd_pos = pos_reg - ldf_pkg::POS_FIRST_RD;
    assign rd_sel = rd_pos[ldf_pkg::READ_W+1:2];

    always_comb begin
        in_packet_next = in_packet_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        lo_hold_next   = lo_hold_reg;
        index_next     = index_reg;
        csum_lo_next   = csum_lo_reg;
        dlo_next       = dlo_reg;
        dhi_next       = dhi_reg;
        inval_next     = inval_reg;
        if (accept) begin
            if (!in_packet_reg) begin
                if (rx_byte == ldf_pkg::START_BYTE) begin
                    in_packet_next = 1'b1;
                    pos_next       = ldf_pkg::POS_INDEX;
                    lo_hold_next   = rx_byte;
                    acc_next       = '0;
                end
            end else if (pos_reg >= ldf_pkg::POS_CSUM_HI) begin
                // packet complete (or position out of range): back to hunting
                in_packet_next = 1'b0;
                pos_next       = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == ldf_pkg::POS_INDEX) begin
                    index_next = rx_byte;
                end
                if (pos_reg < ldf_pkg::POS_CSUM_LO) begin
                    if (pos_reg[0]) begin
                        acc_next = {acc_reg[ldf_pkg::ACC_W-2:0], 1'b0}
                                 + {{(ldf_pkg::ACC_W-16){1'b0}}, rx_byte, lo_hold_reg};
                    end else begin
                        lo_hold_next = rx_byte;
                    end
                    if (pos_reg >= ldf_pkg::POS_FIRST_RD) begin
                        if (rd_pos[1:0] == 2'd0) begin
                            dlo_next[rd_sel] = rx_byte;
                        end else if (rd_pos[1:0] == 2'd1) begin
                            dhi_next[rd_sel]   = rx_byte[5:0];
                            inval_next[rd_sel] = rx_byte[7];
                        end
                    end
                end else begin
                    csum_lo_next = rx_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            in_packet_reg <= in_packet_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        lo_hold_reg <= lo_hold_next;
        index_reg   <= index_next;
        csum_lo_reg <= csum_lo_next;
        dlo_reg     <= dlo_next;
        dhi_reg     <= dhi_next;
        inval_reg   <= inval_next;
    end

    // end-around fold of the running sum, checked against bytes 20..21
    assign fold = {1'b0, acc_reg[ldf_pkg::SUM_W-1:0]}
                + {5'b0, acc_reg[ldf_pkg::ACC_W-1:ldf_pkg::SUM_W]};
    assign sum  = fold[ldf_pkg::SUM_W-1:0];
    assign bad  = cfg.check_enable && ({1'b0, sum} != {rx_byte, csum_lo_reg});
    assign base = {1'b0, index_reg, 2'b00}
                + {{(ldf_pkg::BASE_W-ldf_pkg::ANGLE_W){1'b0}}, cfg.angle_offset};

    always_comb begin
        pkt.done       = accept && last_byte;
        pkt.bad        = bad;
        pkt.base_angle = ldf_pkg::mod360(base);
        for (int k = 0; k < NR; k++) begin
            if (bad || inval_reg[k]) begin
                pkt.distance[k] = ldf_pkg::DIST_INVALID;
            end else begin
                pkt.distance[k] = {1'b0, dhi_reg[k], dlo_reg[k]};
            end
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= ldf_pkg::POS_CSUM_HI)
        else $error("byte position out of range");
    a_hunt_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_packet_reg |-> pos_reg == '0)
        else $error("position nonzero while hunting");
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt.done |=> !in_packet_reg)
        else $error("still in packet after completion");

endmodule

// ===== rtl/ldf_emitter.sv =====
// Reading buffer: holds one decoded packet and sends its four readings.
// Depends on ldf_pkg; loaded by ldf_collector.
`timescale 1ns / 1ps

module ldf_emitter (
    input  logic          aclk,
    input  logic          aresetn,
    input  ldf_pkg::pkt_t pkt,
    output logic          busy,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int NR = ldf_pkg::READINGS_PER_PACKET;

    logic                              full_reg, full_next;
    logic [ldf_pkg::READ_W-1:0]        cnt_reg, cnt_next;
    logic                              bad_reg;
    logic [ldf_pkg::ANGLE_W-1:0]       base_reg;
    logic [NR-1:0][ldf_pkg::DIST_W-1:0] dist_reg;

    logic                              send;
    logic [ldf_pkg::ANGLE_W:0]         ang_sum;
    logic [ldf_pkg::ANGLE_W:0]         ang_wrap;

    assign send = full_reg && m_tready;
    assign busy = full_reg;

    always_comb begin
        full_next = full_reg;
        cnt_next  = cnt_reg;
        if (send) begin
            if (cnt_reg == ldf_pkg::LAST_READING) begin
                full_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (pkt.done) begin
            full_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            full_reg <= full_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt.done) begin
            bad_reg  <= pkt.bad;
            base_reg <= pkt.base_angle;
            dist_reg <= pkt.distance;
        end
    end

    // angle of reading k: base + k, one wrap at most
    assign ang_sum  = {1'b0, base_reg} + {{(ldf_pkg::ANGLE_W-1){1'b0}}, cnt_reg};
    assign ang_wrap = (ang_sum >= 10'd360) ? ang_sum - 10'd360 : ang_sum;

    assign m_tvalid = full_reg;
    assign m_tdata  = {dist_reg[cnt_reg], ang_wrap[ldf_pkg::ANGLE_W-1:0]};
    assign m_tuser  = bad_reg;
    assign m_tlast  = (cnt_reg == ldf_pkg::LAST_READING);

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt.done |-> !full_reg)
        else $error("packet loaded over unsent readings");
    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        send && m_tlast |=> !full_reg)
        else $error("buffer still full after last reading");
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> m_tdata[ldf_pkg::ANGLE_W-1:0] < 9'd360)
        else $error("angle not reduced");
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !full_reg |-> cnt_reg == '0)
        else $error("reading count nonzero while empty");

endmodule
